FILE: rtl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CoeffW   = 16;

  localparam logic [CfgIdxW-1:0] RegC1 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegC2 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegC3 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegC4 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegC5 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegC6 = 3'd5;

  // first-order constants
  localparam logic [18:0] TempRef    = 19'd2000;  // 20.00 C
  localparam logic [18:0] TempVlowOf = 19'd3500;  // -15.00 C seen from 20.00 C

  typedef struct packed {
    logic [23:0] pressure_raw;
    logic [23:0] temperature_raw;
  } bpc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_out;
    logic signed [31:0] pressure_out;
  } bpc_out_t;

  typedef struct packed {
    logic [CoeffW-1:0] c1;
    logic [CoeffW-1:0] c2;
    logic [CoeffW-1:0] c3;
    logic [CoeffW-1:0] c4;
    logic [CoeffW-1:0] c5;
    logic [CoeffW-1:0] c6;
  } bpc_coeff_t;

  // first-order results; all signed fields are two's complement bit vectors
  typedef struct packed {
    logic        valid;
    logic [23:0] d1;
    logic [18:0] temp;  // TEMP
    logic [18:0] a;     // TEMP - 2000
    logic [18:0] b;     // TEMP + 1500
    logic        low;   // TEMP < 2000
    logic        vlow;  // TEMP < -1500
    logic [36:0] off;
    logic [35:0] sens;
    logic [17:0] t2;    // dT^2 >> 31, before gating
  } bpc_front_t;

  // corrected terms, ready for the pressure product
  typedef struct packed {
    logic        valid;
    logic [23:0] d1;
    logic [31:0] tout;
    logic [39:0] off_c;
    logic [39:0] sens_c;
  } bpc_corr_t;

endpackage

`default_nettype wire

FILE: rtl/bpc_coeff_regs.sv
`default_nettype none

module bpc_coeff_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CoeffW-1:0]   cfg_wdata_i,
  output bpc_pkg::bpc_coeff_t          coeff_o
);
  import bpc_pkg::*;

  bpc_coeff_t coeff_q, coeff_d;

  always_comb begin
    coeff_d = coeff_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegC1:   coeff_d.c1 = cfg_wdata_i;
        RegC2:   coeff_d.c2 = cfg_wdata_i;
        RegC3:   coeff_d.c3 = cfg_wdata_i;
        RegC4:   coeff_d.c4 = cfg_wdata_i;
        RegC5:   coeff_d.c5 = cfg_wdata_i;
        RegC6:   coeff_d.c6 = cfg_wdata_i;
        default: coeff_d = coeff_q;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  assign coeff_o = coeff_q;

endmodule

`default_nettype wire

FILE: rtl/bpc_front.sv
`default_nettype none

module bpc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  bpc_pkg::bpc_in_t     in_i,
  input  bpc_pkg::bpc_coeff_t  coeff_i,
  output bpc_pkg::bpc_front_t  front_o
);
  import bpc_pkg::*;

  // stage 1: dT
  logic               v1_q;
  logic [23:0]        d1_1_q;
  logic signed [24:0] dt_d, dt_q;

  // stage 2: products with dT
  logic               v2_q;
  logic [23:0]        d1_2_q;
  logic signed [40:0] p6_d, p4_d, p3_d;
  logic signed [40:0] p6_q, p4_q, p3_q;
  logic signed [49:0] pdd_d, pdd_q;

  // stage 3: TEMP, OFF, SENS
  logic        v3_q;
  logic [23:0] d1_3_q;
  logic [18:0] a_d, temp_d, b_d;
  logic [36:0] off_d;
  logic [35:0] sens_d;
  logic [18:0] temp_q, a_q, b_q;
  logic [36:0] off_q;
  logic [35:0] sens_q;
  logic [17:0] t2_q;

  assign dt_d = $signed({1'b0, in_i.temperature_raw}) - $signed({1'b0, coeff_i.c5, 8'h00});

  assign p6_d  = dt_q * $signed({1'b0, coeff_i.c6});
  assign p4_d  = dt_q * $signed({1'b0, coeff_i.c4});
  assign p3_d  = dt_q * $signed({1'b0, coeff_i.c3});
  assign pdd_d = dt_q * dt_q;

  // floor shifts are plain bit-selects of the signed products
  assign a_d    = {p6_q[40], p6_q[40:23]};
  assign temp_d = a_d + TempRef;
  assign b_d    = a_d + TempVlowOf;
  assign off_d  = {5'b0, coeff_i.c2, 16'h0000} + {{3{p4_q[40]}}, p4_q[40:7]};
  assign sens_d = {5'b0, coeff_i.c1, 15'h0000} + {{3{p3_q[40]}}, p3_q[40:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_1_q <= in_i.pressure_raw;
    dt_q   <= dt_d;
    d1_2_q <= d1_1_q;
    p6_q   <= p6_d;
    p4_q   <= p4_d;
    p3_q   <= p3_d;
    pdd_q  <= pdd_d;
    d1_3_q <= d1_2_q;
    temp_q <= temp_d;
    a_q    <= a_d;
    b_q    <= b_d;
    off_q  <= off_d;
    sens_q <= sens_d;
    t2_q   <= pdd_q[48:31];
  end

  assign front_o.valid = v3_q;
  assign front_o.d1    = d1_3_q;
  assign front_o.temp  = temp_q;
  assign front_o.a     = a_q;
  assign front_o.b     = b_q;
  assign front_o.low   = a_q[18];
  assign front_o.vlow  = b_q[18];
  assign front_o.off   = off_q;
  assign front_o.sens  = sens_q;
  assign front_o.t2    = t2_q;

endmodule

`default_nettype wire

FILE: rtl/bpc_second_order.sv
`default_nettype none

module bpc_second_order (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpc_pkg::bpc_front_t  front_i,
  output bpc_pkg::bpc_corr_t   corr_o
);
  import bpc_pkg::*;

  // stage 4: squares
  logic               v4_q;
  bpc_front_t         f4_q;
  logic signed [37:0] aa_d, bb_d;
  logic [35:0]        aa_q, bb_q;

  // stage 5: OFF2, SENS2
  logic        v5_q;
  bpc_front_t  f5_q;
  logic [39:0] five_aa, seven_bb, eleven_bb;
  logic [39:0] off2_d, sens2_d, off2_q, sens2_q;

  // stage 6: corrected terms
  logic        v6_q;
  logic [23:0] d1_6_q;
  logic [31:0] tout_d, tout_q;
  logic [39:0] off_c_d, sens_c_d, off_c_q, sens_c_q;

  assign aa_d = $signed(front_i.a) * $signed(front_i.a);
  assign bb_d = $signed(front_i.b) * $signed(front_i.b);

  assign five_aa   = {2'b0, aa_q, 2'b0} + {4'b0, aa_q};
  assign seven_bb  = {1'b0, bb_q, 3'b0} - {4'b0, bb_q};
  assign eleven_bb = {1'b0, bb_q, 3'b0} + {3'b0, bb_q, 1'b0} + {4'b0, bb_q};

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    if (f4_q.low) begin
      off2_d  = {1'b0, five_aa[39:1]};
      sens2_d = {2'b0, five_aa[39:2]};
      if (f4_q.vlow) begin
        off2_d  = {1'b0, five_aa[39:1]} + seven_bb;
        sens2_d = {2'b0, five_aa[39:2]} + {1'b0, eleven_bb[39:1]};
      end
    end
  end

  // T2 only counts below 20.00 C
  assign tout_d   = {{13{f5_q.temp[18]}}, f5_q.temp} -
                    (f5_q.low ? {14'b0, f5_q.t2} : 32'd0);
  assign off_c_d  = {{3{f5_q.off[36]}}, f5_q.off} - off2_q;
  assign sens_c_d = {{4{f5_q.sens[35]}}, f5_q.sens} - sens2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= front_i.valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f4_q     <= front_i;
    aa_q     <= aa_d[35:0];
    bb_q     <= bb_d[35:0];
    f5_q     <= f4_q;
    off2_q   <= off2_d;
    sens2_q  <= sens2_d;
    d1_6_q   <= f5_q.d1;
    tout_q   <= tout_d;
    off_c_q  <= off_c_d;
    sens_c_q <= sens_c_d;
  end

  assign corr_o.valid  = v6_q;
  assign corr_o.d1     = d1_6_q;
  assign corr_o.tout   = tout_q;
  assign corr_o.off_c  = off_c_q;
  assign corr_o.sens_c = sens_c_q;

endmodule

`default_nettype wire

FILE: rtl/bpc_pressure.sv
`default_nettype none

module bpc_pressure (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpc_pkg::bpc_corr_t  corr_i,
  output logic                out_valid_o,
  output bpc_pkg::bpc_out_t   out_o
);
  import bpc_pkg::*;

  // stage 7: D1 x SENS in two halves
  logic               v7_q;
  logic signed [43:0] hi_d, hi_q;
  logic [43:0]        lo_d, lo_q;
  logic [39:0]        off_7_q;
  logic [31:0]        tout_7_q;

  // stage 8: full product
  logic        v8_q;
  logic [63:0] prod_d, prod_q;
  logic [39:0] off_8_q;
  logic [31:0] tout_8_q;

  // stage 9: output word
  logic        v9_q;
  logic [63:0] x_d;
  logic [31:0] press_q, tout_9_q;

  assign hi_d = $signed({1'b0, corr_i.d1}) * $signed(corr_i.sens_c[39:20]);
  assign lo_d = corr_i.d1 * corr_i.sens_c[19:0];

  assign prod_d = {hi_q, 20'h00000} + {20'h00000, lo_q};

  assign x_d = {{21{prod_q[63]}}, prod_q[63:21]} - {{24{off_8_q[39]}}, off_8_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v7_q <= corr_i.valid;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    off_7_q  <= corr_i.off_c;
    tout_7_q <= corr_i.tout;
    prod_q   <= prod_d;
    off_8_q  <= off_7_q;
    tout_8_q <= tout_7_q;
    press_q  <= x_d[46:15];
    tout_9_q <= tout_8_q;
  end

  assign out_valid_o           = v9_q;
  assign out_o.temperature_out = tout_9_q;
  assign out_o.pressure_out    = press_q;

endmodule

`default_nettype wire

FILE: rtl/baro_pressure_temp_compensation.sv
// Pipeline: a word taken at an edge shows on out_o with out_valid_o high after
//   nine register stages, one cycle wide.
// Throughput: one word per clock; busy_o never rises, the pipeline always moves.
// The receiver cannot stall; results are strobed for exactly one cycle.
// Reset (rst_ni low, async): calibration words clear to zero, all stage valid
//   bits clear; payload flops are not reset.
`default_nettype none

module baro_pressure_temp_compensation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         start_i,
  input  bpc_pkg::bpc_in_t             in_i,
  output logic                         busy_o,
  // calibration write port
  input  logic                         cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CoeffW-1:0]   cfg_wdata_i,
  // result strobe
  output logic                         out_valid_o,
  output bpc_pkg::bpc_out_t            out_o
);
  import bpc_pkg::*;

  bpc_coeff_t coeff;
  bpc_front_t front_s;
  bpc_corr_t  corr_s;
  logic       in_valid;

  // Fully pipelined, no back pressure anywhere: always ready.
  assign busy_o   = 1'b0;
  assign in_valid = start_i && !busy_o;

  // Calibration words C1..C6.
  bpc_coeff_regs u_coeff (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coeff_o     (coeff)
  );

  // Stages 1-3: dT, the four dT products, then TEMP / OFF / SENS and the
  // cold / very-cold flags.
  bpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_i       (in_i),
    .coeff_i    (coeff),
    .front_o    (front_s)
  );

  // Stages 4-6: squares of (TEMP-2000) and (TEMP+1500), OFF2 / SENS2,
  // then OFF-OFF2, SENS-SENS2 and TEMP-T2. OFF2 and SENS2 use the
  // uncorrected TEMP.
  bpc_second_order u_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front_s),
    .corr_o  (corr_s)
  );

  // Stages 7-9: D1*SENS as two 24x20 partial products, recombined,
  // then the two floor shifts; pressure keeps its low 32 bits.
  bpc_pressure u_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .corr_i      (corr_s),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  // every result comes from an accepted word
  a_out_from_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start_i && !busy_o, 9))
    else $error("result strobe without matching accepted word");

  // corrected stage never runs ahead of the first-order stage
  a_corr_from_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    corr_s.valid |-> $past(front_s.valid, 3))
    else $error("second-order stage valid without first-order word");

  // at or above 20.00 C the reported temperature is TEMP unchanged
  a_warm_no_t2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_s.valid && !front_s.low) |-> ##3
      (corr_s.valid &&
       corr_s.tout == {{13{$past(front_s.temp[18], 3)}}, $past(front_s.temp, 3)}))
    else $error("T2 applied above 20.00 C");
`endif

endmodule

`default_nettype wire

FILE: test/bpc_result_checker.sv
`default_nettype none

// Watches the command, calibration and result channels, predicts each
// compensated word and compares it with what the block returns.
module bpc_result_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  bpc_pkg::bpc_in_t             in_i,
  input  logic                         cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CoeffW-1:0]   cfg_wdata_i,
  input  logic                         out_valid_i,
  input  bpc_pkg::bpc_out_t            out_i,
  output int                           n_err_o,
  output int                           n_pending_o
);
  import bpc_pkg::*;

  localparam longint TempRefC  = 2000;
  localparam longint TempVlowC = -1500;

  bpc_coeff_t cal;
  bpc_out_t   comp_q[$];

  // second-order compensation, all in 64-bit signed arithmetic
  function automatic bpc_out_t compensate(bpc_in_t w, bpc_coeff_t k);
    longint   d1, d2, c1, c2, c3, c4, c5, c6;
    longint   dt, temp, off, sens, t2, off2, sens2, a, b, press, tout;
    bpc_out_t r;
    d1 = longint'(w.pressure_raw);
    d2 = longint'(w.temperature_raw);
    c1 = longint'(k.c1);
    c2 = longint'(k.c2);
    c3 = longint'(k.c3);
    c4 = longint'(k.c4);
    c5 = longint'(k.c5);
    c6 = longint'(k.c6);
    dt    = d2 - c5 * 256;
    temp  = TempRefC + ((dt * c6) >>> 23);
    off   = c2 * 65536 + ((c4 * dt) >>> 7);
    sens  = c1 * 32768 + ((c3 * dt) >>> 8);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (temp < TempRefC) begin
      // corrections use TEMP before T2 is taken off
      a     = temp - TempRefC;
      t2    = (dt * dt) >>> 31;
      off2  = (5 * a * a) >>> 1;
      sens2 = (5 * a * a) >>> 2;
      if (temp < TempVlowC) begin
        b     = temp - TempVlowC;
        off2  = off2 + 7 * b * b;
        sens2 = sens2 + ((11 * b * b) >>> 1);
      end
    end
    press = (((d1 * (sens - sens2)) >>> 21) - (off - off2)) >>> 15;
    tout  = temp - t2;
    r.temperature_out = tout[31:0];
    r.pressure_out    = press[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bpc_out_t want;
    if (!rst_ni) begin
      cal = '0;
      comp_q.delete();
      n_err_o = 0;
      n_pending_o <= 0;
    end else begin
      if (out_valid_i !== 1'b0) begin
        if (comp_q.size() == 0) begin
          $error("unexpected result: temperature_out %0d pressure_out %0d",
                 out_i.temperature_out, out_i.pressure_out);
          n_err_o++;
        end else begin
          want = comp_q.pop_front();
          if (out_i.temperature_out !== want.temperature_out) begin
            $error("temperature_out: expected %0d, got %0d",
                   want.temperature_out, out_i.temperature_out);
            n_err_o++;
          end
          if (out_i.pressure_out !== want.pressure_out) begin
            $error("pressure_out: expected %0d, got %0d",
                   want.pressure_out, out_i.pressure_out);
            n_err_o++;
          end
        end
      end
      // prediction uses the calibration in force before this edge's write
      if (start_i === 1'b1 && busy_i === 1'b0) comp_q.push_back(compensate(in_i, cal));
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          RegC1: cal.c1 = cfg_wdata_i;
          RegC2: cal.c2 = cfg_wdata_i;
          RegC3: cal.c3 = cfg_wdata_i;
          RegC4: cal.c4 = cfg_wdata_i;
          RegC5: cal.c5 = cfg_wdata_i;
          RegC6: cal.c6 = cfg_wdata_i;
          default: ;
        endcase
      end
      n_pending_o <= comp_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

// Stimulus and verdict for the barometer compensation pipeline. The checker
// beside the block does all prediction and comparison.
module tb;
  import bpc_pkg::*;

  // indexes past the sixth word: writes there must leave the calibration alone
  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  // datasheet-like calibration, puts TEMP near 20.00 C for realistic D2
  localparam bpc_coeff_t TypCal = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                    c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

  localparam int NPhases      = 8;
  localparam int WordsPerPhase = 225;

  typedef enum int {CAL_ZERO, CAL_ONES, CAL_TYPICAL, CAL_RANDOM} cal_kind_e;

  cal_kind_e phase_cal[NPhases] = '{CAL_ONES, CAL_RANDOM, CAL_TYPICAL, CAL_RANDOM,
                                    CAL_ZERO, CAL_RANDOM, CAL_TYPICAL, CAL_RANDOM};
  // sender idle percentage per phase; zero phases give back-to-back streams
  int phase_idle[NPhases] = '{0, 53, 15, 0, 53, 15, 0, 53};

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  bpc_in_t             in_w      = '0;
  logic                busy;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CoeffW-1:0]   cfg_wdata = '0;
  logic                res_valid;
  bpc_out_t            res;
  int                  n_err;
  int                  n_pending;

  // stimulus-side copy of the calibration, only used to aim D2
  bpc_coeff_t cal      = '0;
  int         idle_pct = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  baro_pressure_temp_compensation dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .in_i        (in_w),
    .busy_o      (busy),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .out_valid_o (res_valid),
    .out_o       (res)
  );

  bpc_result_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .in_i        (in_w),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .out_valid_i (res_valid),
    .out_i       (res),
    .n_err_o     (n_err),
    .n_pending_o (n_pending)
  );

  function automatic logic [23:0] clamp24(longint v);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > 64'sd16777215) c = 64'sd16777215;
    return c[23:0];
  endfunction

  // D2 that lands TEMP at exactly 2000 + k (k <= 0); division truncates to
  // zero, which is the ceiling for negative k
  function automatic logic [23:0] d2_for_temp(int k);
    longint dt;
    dt = 0;
    if (cal.c6 != '0) dt = (longint'(k) * 8388608) / longint'(cal.c6);
    return clamp24(longint'(cal.c5) * 256 + dt);
  endfunction

  // random word: half uniform D2, half clustered around dT = 0 with a
  // random spread, so both correction branches and their edges get hit
  function automatic bpc_in_t gen_word();
    bpc_in_t     w;
    logic [31:0] r1, r2, r3;
    longint      span, dev;
    r1 = $urandom;
    r2 = $urandom;
    r3 = $urandom;
    w.pressure_raw = r1[23:0];
    if (r3[2:0] == 3'd0) w.pressure_raw = '0;
    if (r3[2:0] == 3'd1) w.pressure_raw = '1;
    if (r3[3]) begin
      w.temperature_raw = r2[23:0];
    end else begin
      span = longint'(1) << r3[12:8] % 25;
      dev  = longint'(r2) % span;
      if (r3[4]) dev = -dev;
      w.temperature_raw = clamp24(longint'(cal.c5) * 256 + dev);
    end
    if (r3[7:5] == 3'd0) w.temperature_raw = '0;
    if (r3[7:5] == 3'd1) w.temperature_raw = '1;
    return w;
  endfunction

  function automatic bpc_coeff_t gen_cal(cal_kind_e kind);
    bpc_coeff_t  k;
    logic [31:0] r;
    case (kind)
      CAL_ZERO:    k = '0;
      CAL_ONES:    k = '1;
      CAL_TYPICAL: k = TypCal;
      default: begin
        r = $urandom;
        k.c1 = r[15:0];
        k.c2 = r[31:16];
        r = $urandom;
        k.c3 = r[15:0];
        k.c4 = r[31:16];
        r = $urandom;
        k.c5 = r[15:0];
        k.c6 = r[31:16];
      end
    endcase
    return k;
  endfunction

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CoeffW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      RegC1: cal.c1 = val;
      RegC2: cal.c2 = val;
      RegC3: cal.c3 = val;
      RegC4: cal.c4 = val;
      RegC5: cal.c5 = val;
      RegC6: cal.c6 = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // only called with the pipeline empty
  task automatic load_cal(bpc_coeff_t k);
    logic [31:0] r;
    r = $urandom;
    cfg_write(RegC1, k.c1);
    cfg_write(RegC2, k.c2);
    cfg_write(RegC3, k.c3);
    cfg_write(RegC4, k.c4);
    cfg_write(RegC5, k.c5);
    cfg_write(RegC6, k.c6);
    cfg_write(r[16] ? RegSpareA : RegSpareB, r[15:0]);
    cfg_we <= 1'b0;
  endtask

  // hold off the sender until every predicted word has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // start stays high after acceptance so back-to-back words need no toggle
  task automatic send(logic [23:0] p, logic [23:0] t);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_w  <= gen_word();
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_w  <= '{pressure_raw: p, temperature_raw: t};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  initial begin
    bpc_in_t w;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calibration still at its reset value
    send('1, '1);
    send('0, '0);

    // typical calibration: both temperature thresholds from either side
    drain();
    load_cal(TypCal);
    send('1, d2_for_temp(0));
    send('0, d2_for_temp(0));
    send(24'h800000, d2_for_temp(-1));
    send(24'h8A0000, d2_for_temp(-3500));
    send(24'h8A0000, d2_for_temp(-3501));
    send('1, '0);
    send('0, '1);
    send(24'h5A5A5A, 24'hA5A5A5);

    // spare index writes must not disturb the calibration
    drain();
    cfg_write(RegSpareA, '1);
    cfg_write(RegSpareB, '1);
    cfg_we <= 1'b0;
    send(24'h8A0000, d2_for_temp(-1));

    // every calibration word at full scale: deepest corrections, largest products
    drain();
    load_cal(gen_cal(CAL_ONES));
    send('1, '0);
    send('1, '1);
    send('0, '0);
    send('1, d2_for_temp(0));
    send('1, d2_for_temp(-1));

    for (int ph = 0; ph < NPhases; ph++) begin
      drain();
      load_cal(gen_cal(phase_cal[ph]));
      idle_pct = phase_idle[ph];
      for (int i = 0; i < WordsPerPhase; i++) begin
        w = gen_word();
        send(w.pressure_raw, w.temperature_raw);
        // one mid-stream pause that lets the pipeline run dry
        if (ph == 1 && i == WordsPerPhase / 2) drain();
      end
    end

    start <= 1'b0;
    for (int n = 0; n < 2000 && n_pending != 0; n++) @(posedge clk);
    repeat (12) @(posedge clk);
    if (n_pending != 0) $error("%0d predicted words never came back", n_pending);
    if (n_err == 0 && n_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/bpc_pkg.sv
rtl/bpc_coeff_regs.sv
rtl/bpc_front.sv
rtl/bpc_second_order.sv
rtl/bpc_pressure.sv
rtl/baro_pressure_temp_compensation.sv
test/bpc_result_checker.sv
test/tb.sv
